// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pps_pkg.sv =====
package pps_pkg;

	// command codes
	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_POST
	} state_t;

	// one command transaction
	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  slot;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  priority_req;
	} cmd_t;

	// one tick result transaction
	typedef struct packed {
		logic        ran_task;
		logic [3:0]  ran_slot;
		logic        task_done;
		logic [23:0] finish_time;
		logic [23:0] turnaround;
		logic [23:0] waiting;
		logic [31:0] sum_turnaround;
		logic [31:0] sum_waiting;
		logic [23:0] idle_ticks;
		logic        all_done;
	} res_t;

	// one task table entry
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} entry_t;

	// sequencer to selector controls
	typedef struct packed {
		logic start;
		logic cmp_en;
		logic pending;
	} sel_ctrl_t;

	localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
	localparam logic [31:0] SUM_MAX  = 32'hFFFFFFFF;

endpackage

// ===== rtl/preemptive_priority_scheduler_unit.sv =====
// channel | signals                      | accepted when
// command | cmd_valid, cmd_ready, cmd    | cmd_valid && cmd_ready
// result  | res_valid, res_ready, res    | res_valid && res_ready
//
// a load, clear or unused code is handled in idle and leaves the block in idle
// a tick is accepted in idle, then reads each of the SLOTS entries through the table
// memory read port, waits for the last read data, then runs one update and one commit
// the table memory has no reset; valid and finished bits clear at reset
// a finished tick waits in the commit step while the result register is full
module preemptive_priority_scheduler_unit #(
	parameter int SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pps_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output pps_pkg::res_t res
);
	import pps_pkg::*;

	localparam int IW = $clog2(SLOTS);

	state_t          state_q, state_d;
	logic [IW:0]     cnt_q;
	logic            rd_vld_s1;
	logic [IW-1:0]   rd_idx_s1;
	logic [SLOTS-1:0] valid_q, fin_q, pend;
	logic [23:0]     time_q, idle_q;
	logic [31:0]     tot_tat_q, tot_wt_q;
	logic            done_s2;
	logic [23:0]     tat_s2;
	res_t            res_q;
	logic            res_valid_q;

	logic            acc, is_load, is_tick, is_clear, load_ok, commit;
	logic [IW-1:0]   load_idx;
	logic            mem_we, mem_re;
	logic [IW-1:0]   mem_waddr;
	entry_t          mem_wdata, mem_rdata;
	sel_ctrl_t       sel_ctrl;
	logic            found;
	logic [IW-1:0]   best_idx;
	entry_t          best;
	logic [15:0]     rem_new;
	logic [23:0]     time_inc, tat_c, wt_c;
	logic            done_c;
	logic [32:0]     tat_sum, wt_sum;
	logic [31:0]     tot_tat_d, tot_wt_d;

	// command decode
	assign acc      = cmd_valid && cmd_ready;
	assign is_load  = acc && (cmd.mode == MODE_LOAD);
	assign is_tick  = acc && (cmd.mode == MODE_TICK);
	assign is_clear = acc && (cmd.mode == MODE_CLEAR);
	assign load_ok  = is_load && (32'(cmd.slot) < 32'(SLOTS));
	assign load_idx = IW'(cmd.slot);
	assign pend     = valid_q & ~fin_q;
	assign commit   = (state_q == ST_POST) && (!res_valid_q || res_ready);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		mem_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (is_tick) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				mem_re = (cnt_q < (IW + 1)'(SLOTS));
				if (cnt_q == (IW + 1)'(SLOTS)) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_POST;
			end
			ST_POST: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// scan address counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			if (is_tick) begin
				cnt_q <= '0;
			end else if (mem_re) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IW-1:0];
	end

	// table write port: loads in idle, remaining-time writeback in update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = load_idx;
		mem_wdata = '{arrival: cmd.arrival, burst: cmd.burst, remaining: cmd.burst,
			prio: cmd.priority_req};
		if (load_ok) begin
			mem_we = 1'b1;
		end else if ((state_q == ST_CALC) && found) begin
			mem_we              = 1'b1;
			mem_waddr           = best_idx;
			mem_wdata           = best;
			mem_wdata.remaining = rem_new;
		end
	end

	pps_table_mem #(.SLOTS(SLOTS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (cnt_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	// selector controls
	assign sel_ctrl.start   = is_tick;
	assign sel_ctrl.cmp_en  = rd_vld_s1;
	assign sel_ctrl.pending = pend[rd_idx_s1];

	pps_select #(.SLOTS(SLOTS)) u_sel (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (sel_ctrl),
		.idx        (rd_idx_s1),
		.rdata      (mem_rdata),
		.now        (time_q),
		.found      (found),
		.best_idx   (best_idx),
		.best_entry (best)
	);

	// update step arithmetic
	assign rem_new  = best.remaining - 16'(best.remaining != 16'd0);
	assign time_inc = (time_q == TIME_MAX) ? time_q : time_q + 24'd1;
	assign done_c   = (rem_new == 16'd0);
	assign tat_c    = time_inc - {8'd0, best.arrival};

	// commit step arithmetic
	assign wt_c      = (tat_s2 >= {8'd0, best.burst}) ? tat_s2 - {8'd0, best.burst} : 24'd0;
	assign tat_sum   = {1'b0, tot_tat_q} + 33'(tat_s2);
	assign wt_sum    = {1'b0, tot_wt_q} + 33'(wt_c);
	assign tot_tat_d = !done_s2 ? tot_tat_q : (tat_sum[32] ? SUM_MAX : tat_sum[31:0]);
	assign tot_wt_d  = !done_s2 ? tot_wt_q : (wt_sum[32] ? SUM_MAX : wt_sum[31:0]);

	// slot valid and finished bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fin_q   <= '0;
		end else begin
			if (is_clear) begin
				valid_q <= '0;
				fin_q   <= '0;
			end else if (load_ok) begin
				valid_q[load_idx] <= (cmd.burst != 16'd0);
				fin_q[load_idx]   <= 1'b0;
			end else if ((state_q == ST_CALC) && found && done_c) begin
				fin_q[best_idx] <= 1'b1;
			end
		end
	end

	// time, idle count and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			idle_q    <= '0;
			tot_tat_q <= '0;
			tot_wt_q  <= '0;
		end else begin
			if (state_q == ST_CALC) begin
				time_q <= time_inc;
				if (!found && (|pend) && (idle_q != TIME_MAX)) begin
					idle_q <= idle_q + 24'd1;
				end
			end
			if (commit) begin
				tot_tat_q <= tot_tat_d;
				tot_wt_q  <= tot_wt_d;
			end
		end
	end

	// update results carried into the commit step
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			done_s2 <= found && done_c;
			tat_s2  <= tat_c;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (commit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q.ran_task       <= found;
			res_q.ran_slot       <= found ? 4'(best_idx) : 4'd0;
			res_q.task_done      <= done_s2;
			res_q.finish_time    <= time_q;
			res_q.turnaround     <= done_s2 ? tat_s2 : 24'd0;
			res_q.waiting        <= done_s2 ? wt_c : 24'd0;
			res_q.sum_turnaround <= tot_tat_d;
			res_q.sum_waiting    <= tot_wt_d;
			res_q.idle_ticks     <= idle_q;
			res_q.all_done       <= ~|pend;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/pps_table_mem.sv =====
module pps_table_mem #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(SLOTS)-1:0]   waddr,
	input  pps_pkg::entry_t            wdata,
	input  logic                       re,
	input  logic [$clog2(SLOTS)-1:0]   raddr,
	output pps_pkg::entry_t            rdata
);
	import pps_pkg::*;

	entry_t mem [SLOTS];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/pps_select.sv =====
module pps_select #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pps_pkg::sel_ctrl_t         ctrl,
	input  logic [$clog2(SLOTS)-1:0]   idx,
	input  pps_pkg::entry_t            rdata,
	input  logic [23:0]                now,
	output logic                       found,
	output logic [$clog2(SLOTS)-1:0]   best_idx,
	output pps_pkg::entry_t            best_entry
);
	import pps_pkg::*;

	localparam int IW = $clog2(SLOTS);

	logic          found_q;
	logic [IW-1:0] best_idx_q;
	entry_t        best_q;
	logic          take;

	// eligible, arrived, and strictly better than the best so far
	assign take = ctrl.cmp_en && ctrl.pending && ({8'd0, rdata.arrival} <= now)
		&& (!found_q || (rdata.prio < best_q.prio));

	// found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// best candidate payload
	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= idx;
			best_q     <= rdata;
		end
	end

	assign found      = found_q;
	assign best_idx   = best_idx_q;
	assign best_entry = best_q;

endmodule

// ===== rtl/pps_checker.sv =====
`include "assert_macros.svh"

module pps_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_ready,
	input pps_pkg::cmd_t cmd,
	input logic          res_valid,
	input logic          res_ready,
	input pps_pkg::res_t res
);
	import pps_pkg::*;

	// a stalled result holds
	`ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

	// a tick occupies the block past its accept cycle
	`ASSERT_NEXT(a_tick_busy, cmd_valid && cmd_ready && (cmd.mode == MODE_TICK), !cmd_ready, "command taken during a tick")

	// an idle tick reports no slot and no completion
	`ASSERT_SAME(a_idle_res, res_valid && !res.ran_task, (res.ran_slot == 4'd0) && !res.task_done && (res.turnaround == 24'd0), "idle tick carries task data")

	// waiting never exceeds turnaround
	`ASSERT_SAME(a_wait_le_tat, res_valid && res.task_done, res.waiting <= res.turnaround, "waiting above turnaround")

	// totals cover the reported completion
	`ASSERT_SAME(a_sum_cover, res_valid && res.task_done, (res.sum_turnaround >= 32'(res.turnaround)) && (res.sum_waiting >= 32'(res.waiting)), "running total below this completion")

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);

// ===== tb/sv/tb_preemptive_priority_scheduler_unit.sv =====
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler_unit;
	import pps_pkg::*;

	localparam int SLOTS = 16;
	localparam int ITEM_TARGET = 500;
	localparam int CYCLE_LIMIT = 400000;
	// the 2-bit mode field has one code the block ignores
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// directed stimulus row: command plus an optional hand-written result
	typedef struct {
		cmd_t c;
		bit   typed;
		res_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	// scheduler state mirror
	logic [SLOTS-1:0] task_valid;
	logic [SLOTS-1:0] task_finished;
	logic [15:0]      task_arrival [SLOTS];
	logic [15:0]      task_burst [SLOTS];
	logic [15:0]      task_left [SLOTS];
	logic [7:0]       task_prio [SLOTS];
	logic [23:0]      sched_time;
	logic [31:0]      tat_total;
	logic [31:0]      wait_total;
	logic [23:0]      idle_total;

	res_t      tick_results_q [$];
	stim_row_t directed_rows [$];

	int fail_count = 0;
	int cycle_count = 0;
	int cmds_sent = 0;
	int ticks_seen = 0;
	int completions_seen = 0;
	int idle_seen = 0;
	int burst_left = 0;

	preemptive_priority_scheduler_unit #(
		.SLOTS(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("preemptive_priority_scheduler_unit regression: fail");
			$finish;
		end
	end

	// result back-pressure, pattern chosen by cycle_count bits 8:7
	always @(posedge clk) begin
		case (cycle_count[8:7])
		2'd0: res_ready <= 1'b1;
		2'd1: res_ready <= 1'($urandom_range(0, 1));
		2'd2: res_ready <= (cycle_count[2:0] == 3'd0);
		default: res_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [23:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[32] ? SUM_MAX : s[31:0];
	endfunction

	function automatic bit tasks_open();
		return |(task_valid & ~task_finished);
	endfunction

	// advance the scheduler mirror by one command, give the tick result if any
	task automatic run_scheduler(input cmd_t c, output bit has_res, output res_t r);
		int unsigned pick;
		bit found;
		bit done;
		logic [23:0] tat;
		logic [23:0] wt;
		has_res = 1'b0;
		r = '0;
		pick = 0;
		found = 1'b0;
		done = 1'b0;
		tat = '0;
		wt = '0;
		case (c.mode)
		MODE_LOAD: begin
			task_arrival[c.slot] = c.arrival;
			task_burst[c.slot] = c.burst;
			task_left[c.slot] = c.burst;
			task_prio[c.slot] = c.priority_req;
			task_finished[c.slot] = 1'b0;
			task_valid[c.slot] = (c.burst != 16'd0);
		end
		MODE_CLEAR: begin
			task_valid = '0;
			task_finished = '0;
		end
		MODE_TICK: begin
			// lowest priority value among arrived open tasks, ties to lowest slot
			for (int i = 0; i < SLOTS; i++) begin
				if (task_valid[i] && !task_finished[i] && {8'd0, task_arrival[i]} <= sched_time) begin
					if (!found || task_prio[i] < task_prio[pick]) begin
						pick = i;
						found = 1'b1;
					end
				end
			end
			if (found) begin
				if (task_left[pick] != 16'd0)
					task_left[pick] = task_left[pick] - 16'd1;
				if (sched_time != TIME_MAX)
					sched_time = sched_time + 24'd1;
				if (task_left[pick] == 16'd0) begin
					done = 1'b1;
					task_finished[pick] = 1'b1;
					tat = sched_time - {8'd0, task_arrival[pick]};
					wt = (tat >= {8'd0, task_burst[pick]}) ? tat - {8'd0, task_burst[pick]} : '0;
					tat_total = sat_add32(tat_total, tat);
					wait_total = sat_add32(wait_total, wt);
				end
			end else begin
				if (tasks_open() && idle_total != TIME_MAX)
					idle_total = idle_total + 24'd1;
				if (sched_time != TIME_MAX)
					sched_time = sched_time + 24'd1;
			end
			has_res = 1'b1;
			r.ran_task = found;
			r.ran_slot = found ? 4'(pick) : 4'd0;
			r.task_done = done;
			r.finish_time = sched_time;
			r.turnaround = tat;
			r.waiting = wt;
			r.sum_turnaround = tat_total;
			r.sum_waiting = wait_total;
			r.idle_ticks = idle_total;
			r.all_done = !tasks_open();
		end
		default: ;
		endcase
	endtask

	// one command transaction with sender bursts and gaps
	task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
		bit has_res;
		res_t r;
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		burst_left--;
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		run_scheduler(c, has_res, r);
		if (has_res)
			tick_results_q.push_back(typed ? want : r);
		if (c.mode != MODE_UNUSED)
			cmds_sent++;
	endtask

	task automatic send_plain(input logic [1:0] mode, input logic [3:0] slot,
			input logic [15:0] arrival, input logic [15:0] burst, input logic [7:0] prio);
		cmd_t c;
		c.mode = mode;
		c.slot = slot;
		c.arrival = arrival;
		c.burst = burst;
		c.priority_req = prio;
		send_cmd(c, 1'b0, '0);
	endtask

	function automatic void add_row(input logic [1:0] mode, input logic [3:0] slot,
			input logic [15:0] arrival, input logic [15:0] burst, input logic [7:0] prio,
			input bit typed, input res_t want);
		stim_row_t row;
		row.c.mode = mode;
		row.c.slot = slot;
		row.c.arrival = arrival;
		row.c.burst = burst;
		row.c.priority_req = prio;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	// arrival near the current time, clamped to 16 bits
	function automatic logic [15:0] near_arrival(input int unsigned ahead);
		logic [24:0] t;
		t = {1'b0, sched_time} + 25'(ahead);
		return (t > 25'd65535) ? 16'hFFFF : t[15:0];
	endfunction

	// a well-formed task mix with random content, plus some noise
	task automatic random_scenario();
		int n_loads;
		int n_ticks;
		int pick;
		if ($urandom_range(0, 3) == 0)
			send_plain(MODE_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
		n_loads = $urandom_range(1, 5);
		for (int i = 0; i < n_loads; i++)
			send_plain(MODE_LOAD, 4'($urandom_range(0, SLOTS - 1)), near_arrival($urandom_range(0, 12)),
				16'($urandom_range(1, 6)),
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
		n_ticks = $urandom_range(4, 25);
		for (int i = 0; i < n_ticks; i++) begin
			pick = $urandom_range(0, 39);
			if (pick < 5) begin
				// late arrival that may preempt the running task
				send_plain(MODE_LOAD, 4'($urandom_range(0, SLOTS - 1)), near_arrival($urandom_range(0, 3)),
					16'($urandom_range(1, 4)), 8'($urandom_range(0, 7)));
			end else if (pick == 5) begin
				send_plain(MODE_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
			end else if (pick == 6) begin
				// zero burst drops the slot
				send_plain(MODE_LOAD, 4'($urandom), 16'($urandom), 16'd0, 8'($urandom));
			end else if (pick == 7) begin
				send_plain(MODE_LOAD, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
			end
			send_plain(MODE_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	task automatic check_result(input res_t got, input res_t want);
		if (got.ran_task !== want.ran_task) begin
			$error("ran_task: expected %0d, got %0d", want.ran_task, got.ran_task);
			fail_count++;
		end
		if (got.ran_slot !== want.ran_slot) begin
			$error("ran_slot: expected %0d, got %0d", want.ran_slot, got.ran_slot);
			fail_count++;
		end
		if (got.task_done !== want.task_done) begin
			$error("task_done: expected %0d, got %0d", want.task_done, got.task_done);
			fail_count++;
		end
		if (got.finish_time !== want.finish_time) begin
			$error("finish_time: expected %0d, got %0d", want.finish_time, got.finish_time);
			fail_count++;
		end
		if (got.turnaround !== want.turnaround) begin
			$error("turnaround: expected %0d, got %0d", want.turnaround, got.turnaround);
			fail_count++;
		end
		if (got.waiting !== want.waiting) begin
			$error("waiting: expected %0d, got %0d", want.waiting, got.waiting);
			fail_count++;
		end
		if (got.sum_turnaround !== want.sum_turnaround) begin
			$error("sum_turnaround: expected %0d, got %0d", want.sum_turnaround, got.sum_turnaround);
			fail_count++;
		end
		if (got.sum_waiting !== want.sum_waiting) begin
			$error("sum_waiting: expected %0d, got %0d", want.sum_waiting, got.sum_waiting);
			fail_count++;
		end
		if (got.idle_ticks !== want.idle_ticks) begin
			$error("idle_ticks: expected %0d, got %0d", want.idle_ticks, got.idle_ticks);
			fail_count++;
		end
		if (got.all_done !== want.all_done) begin
			$error("all_done: expected %0d, got %0d", want.all_done, got.all_done);
			fail_count++;
		end
	endtask

	// result transaction checker
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (tick_results_q.size() == 0) begin
				$error("result transaction with no tick outstanding");
				fail_count++;
			end else begin
				ticks_seen++;
				if (res.task_done)
					completions_seen++;
				if (!res.ran_task)
					idle_seen++;
				check_result(res, tick_results_q.pop_front());
			end
		end
	end

	initial begin
		task_valid = '0;
		task_finished = '0;
		for (int i = 0; i < SLOTS; i++) begin
			task_arrival[i] = '0;
			task_burst[i] = '0;
			task_left[i] = '0;
			task_prio[i] = '0;
		end
		sched_time = '0;
		tat_total = '0;
		wait_total = '0;
		idle_total = '0;

		// directed part: empty table, top priority, never-arriving task, zero burst,
		// tie on priority, preemption, reload of a finished slot, unused mode, clear
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b1,
			'{1'b0, 4'd0, 1'b0, 24'd1, 24'd0, 24'd0, 32'd0, 32'd0, 24'd0, 1'b1});
		add_row(MODE_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, '0);
		add_row(MODE_LOAD, 4'd0, 16'd0, 16'd1, 8'd255, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b1,
			'{1'b1, 4'd0, 1'b1, 24'd2, 24'd2, 24'd1, 32'd2, 32'd1, 24'd0, 1'b1});
		add_row(MODE_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b1,
			'{1'b0, 4'd0, 1'b0, 24'd3, 24'd0, 24'd0, 32'd2, 32'd1, 24'd1, 1'b0});
		add_row(MODE_LOAD, 4'd3, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_LOAD, 4'd5, 16'd0, 16'd3, 8'd10, 1'b0, '0);
		add_row(MODE_LOAD, 4'd2, 16'd0, 16'd2, 8'd10, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_LOAD, 4'd7, 16'd6, 16'd1, 8'd1, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_LOAD, 4'd2, 16'd0, 16'd2, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_CLEAR, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);
		add_row(MODE_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 1'b0, '0);

		// reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

		while (cmds_sent < ITEM_TARGET)
			random_scenario();
		cmd_valid <= 1'b0;

		// drain outstanding ticks, then let the sequencer settle
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		$display("covered %0d commands, %0d tick results (%0d completions, %0d idle ticks)",
			cmds_sent, ticks_seen, completions_seen, idle_seen);
		$display("mixes included preemption, ties, reloads, zero bursts, clears and stalls");
		if (fail_count == 0)
			$display("preemptive_priority_scheduler_unit regression: pass");
		else
			$display("preemptive_priority_scheduler_unit regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_table_mem.sv
rtl/pps_select.sv
rtl/preemptive_priority_scheduler_unit.sv
rtl/pps_checker.sv
tb/sv/tb_preemptive_priority_scheduler_unit.sv
